[design/lmcf_pkg.sv]
// ----------------------------------------------------------------------------
// LED matrix chain frame buffer package
// Shared sizes, request codes and helpers for the frame buffer.
// ----------------------------------------------------------------------------
package lmcf_pkg;

	localparam int MAX_DISPLAYS = 8;
	localparam int STORE_DEPTH  = 8 * MAX_DISPLAYS;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int LEN_W        = $clog2(MAX_DISPLAYS + 1);
	localparam int SIZE_W       = (LEN_W + 3 > 7) ? LEN_W + 3 : 7;

	localparam logic [3:0] CMD_NOOP = 4'h0;
	localparam logic [3:0] CMD_ROW1 = 4'h8;

	typedef enum logic [2:0] {
		REQ_SET_DOT  = 3'd0,
		REQ_CLR_DOT  = 3'd1,
		REQ_SHIFT_R  = 3'd2,
		REQ_SHIFT_L  = 3'd3,
		REQ_REFRESH  = 3'd4,
		REQ_SEND_ONE = 3'd5,
		REQ_SEND_ALL = 3'd6,
		REQ_CLEAR    = 3'd7
	} req_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int b = 0; b < 8; b++) begin
			r[7 - b] = v[b];
		end
		return r;
	endfunction

endpackage

[design/led_matrix_chain_framebuffer.sv]
// ----------------------------------------------------------------------------
// LED matrix chain frame buffer
// Frame store and driver word sequencer for a daisy chain of 8x8 LED matrices.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream, one beat per request; the kind of request
// sits in s_tuser. Driver words leave on the m_ stream with the latch marker in
// m_tuser and the final word of a request flagged by m_tlast. The chain length
// is written through cfg_wen/cfg_wdata; the user must do so while the block is
// idle (the block does not enforce it). The 64-byte store has one write and one
// registered read port; a single sequencer walks it one byte per cycle unless stalled:
//   set or clear dot: read the byte, then write it back;
//   shift left or right: prime and load, then 8*L bytes rewritten, one per cycle;
//   refresh: 8*L words at one word per cycle unless the receiver stalls;
//   send one or send all: L words likewise; send one emits none past the chain;
//   clear store: the valid flags drop as the request is taken.
// L is the chain length in use. s_tready is high only between requests.
// A final word may still wait in the output register when the next request
// is taken. While the receiver stalls, words queue in a one-word read stage
// and the output register, and the sequencer waits. Reset empties the store
// at once through per-byte valid flags, sets the chain length to eight and
// drops all words in flight.
// ----------------------------------------------------------------------------
module led_matrix_chain_framebuffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// x_pos[5:0], y_pos[8:6], chain_index[11:9], command_in[15:12], data_in[23:16]
	input  logic [23:0] s_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_command[3:0], out_data[11:4], zero padding[15:12]
	output logic [15:0] m_tdata,
	// latch[0]
	output logic [0:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_wen,
	input  logic [3:0]  cfg_wdata
);
	import lmcf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DOT_RD, ST_DOT_WR, ST_SH_PRIME, ST_SH_LOAD, ST_SH_RUN, ST_EMIT, ST_DRAIN
	} state_t;

	state_t            state_q;
	logic [3:0]        chain_length_q;
	req_t              req_q;
	logic [5:0]        x_q;
	logic [2:0]        y_q;
	logic [2:0]        nr_q;
	logic [3:0]        cmd_q;
	logic [7:0]        dat_q;

	logic [ADDR_W-1:0] p_q;
	logic [LEN_W-1:0]  col_q;
	logic [7:0]        cur_q;
	logic [LEN_W-1:0]  d_q;
	logic [2:0]        r_q;
	logic [ADDR_W-1:0] base_q;

	logic              pend_q;
	logic [3:0]        pend_cmd_q;
	logic [7:0]        pend_dat_q;
	logic              pend_mem_q;
	logic              pend_latch_q;
	logic              pend_last_q;

	logic              m_valid_q;
	logic [3:0]        m_cmd_q;
	logic [7:0]        m_dat_q;
	logic              m_latch_q;
	logic              m_last_q;

	logic [7:0]             mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	logic [7:0]             rd_q;
	logic                   rdv_q;

	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  len_m1;
	logic [SIZE_W-1:0] size_w;
	logic [ADDR_W-1:0] size_m1;
	logic [7:0]        rd_val;
	logic              accept;
	req_t              s_req;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [7:0]        wd;
	logic              clr;

	logic [ADDR_W-1:0] dot_idx;
	logic              dot_ok;
	logic [7:0]        dot_mask;
	logic              sh_left;
	logic              sh_carry;
	logic              sh_end;
	logic [ADDR_W-1:0] nb1;
	logic [ADDR_W-1:0] nb2;

	logic              out_load;
	logic              issue;
	logic              final_row;
	logic              hit;
	logic [3:0]        gen_cmd;
	logic [7:0]        gen_dat;

	always_comb begin
		if (chain_length_q == 4'd0) begin
			len = LEN_W'(1);
		end else if (32'(chain_length_q) > MAX_DISPLAYS) begin
			len = LEN_W'(MAX_DISPLAYS);
		end else begin
			len = LEN_W'(chain_length_q);
		end
	end

	assign len_m1  = len - LEN_W'(1);
	assign size_w  = SIZE_W'(len) << 3;
	assign size_m1 = ADDR_W'(size_w - SIZE_W'(1));
	assign rd_val  = rdv_q ? rd_q : 8'h00;
	assign accept  = s_tvalid && s_tready;
	assign s_req   = req_t'(s_tuser);

	assign dot_idx  = ADDR_W'(x_q >> 3) + ADDR_W'(len) * ADDR_W'(y_q);
	assign dot_ok   = SIZE_W'(x_q) < size_w;
	assign dot_mask = 8'h80 >> x_q[2:0];

	assign sh_left  = (req_q == REQ_SHIFT_L);
	assign sh_carry = sh_left ? (col_q != len_m1) : (col_q != LEN_W'(0));
	assign sh_end   = sh_left ? (p_q == size_m1) : (p_q == ADDR_W'(0));
	assign nb1      = sh_left ? p_q + ADDR_W'(1) : p_q - ADDR_W'(1);
	assign nb2      = sh_left ? p_q + ADDR_W'(2) : p_q - ADDR_W'(2);

	assign out_load  = pend_q && (!m_valid_q || m_tready);
	assign issue     = (state_q == ST_EMIT) && (!pend_q || out_load);
	assign final_row = (req_q == REQ_REFRESH) ? (r_q == 3'd7) : 1'b1;
	assign hit       = (d_q == LEN_W'(nr_q));

	always_comb begin
		case (req_q)
			REQ_REFRESH: begin
				gen_cmd = CMD_ROW1 - {1'b0, r_q};
				gen_dat = 8'h00;
			end
			REQ_SEND_ONE: begin
				gen_cmd = hit ? cmd_q : CMD_NOOP;
				gen_dat = hit ? dat_q : 8'h00;
			end
			default: begin
				gen_cmd = cmd_q;
				gen_dat = dat_q;
			end
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = p_q;
		we      = 1'b0;
		wa      = p_q;
		wd      = 8'h00;
		clr     = accept && (s_req == REQ_CLEAR);
		case (state_q)
			ST_DOT_RD: begin
				rd_en   = 1'b1;
				rd_addr = dot_idx;
			end
			ST_DOT_WR: begin
				we = dot_ok;
				wa = dot_idx;
				wd = (req_q == REQ_SET_DOT) ? (rd_val | dot_mask) : (rd_val & ~dot_mask);
			end
			ST_SH_PRIME: begin
				rd_en   = 1'b1;
				rd_addr = p_q;
			end
			ST_SH_LOAD: begin
				rd_en   = 1'b1;
				rd_addr = nb1;
			end
			ST_SH_RUN: begin
				rd_en   = 1'b1;
				rd_addr = nb2;
				we      = 1'b1;
				wa      = p_q;
				wd      = sh_left ? {cur_q[6:0], sh_carry & rd_val[7]}
				                  : {sh_carry & rd_val[0], cur_q[7:1]};
			end
			ST_EMIT: begin
				rd_en   = issue && (req_q == REQ_REFRESH);
				rd_addr = base_q + ADDR_W'(d_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rdv_q <= vld_q[rd_addr];
			end
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			chain_length_q <= 4'd8;
			req_q          <= REQ_SET_DOT;
			x_q            <= '0;
			y_q            <= '0;
			nr_q           <= '0;
			cmd_q          <= '0;
			dat_q          <= '0;
			p_q            <= '0;
			col_q          <= '0;
			cur_q          <= '0;
			d_q            <= '0;
			r_q            <= '0;
			base_q         <= '0;
			pend_q         <= 1'b0;
			pend_cmd_q     <= '0;
			pend_dat_q     <= '0;
			pend_mem_q     <= 1'b0;
			pend_latch_q   <= 1'b0;
			pend_last_q    <= 1'b0;
			m_valid_q      <= 1'b0;
			m_cmd_q        <= '0;
			m_dat_q        <= '0;
			m_latch_q      <= 1'b0;
			m_last_q       <= 1'b0;
		end else begin
			if (cfg_wen) begin
				chain_length_q <= cfg_wdata;
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
				m_cmd_q   <= pend_cmd_q;
				m_dat_q   <= pend_mem_q ? rev8(rd_val) : pend_dat_q;
				m_latch_q <= pend_latch_q;
				m_last_q  <= pend_last_q;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			if (issue) begin
				pend_q       <= 1'b1;
				pend_cmd_q   <= gen_cmd;
				pend_dat_q   <= gen_dat;
				pend_mem_q   <= (req_q == REQ_REFRESH);
				pend_latch_q <= (d_q == LEN_W'(0));
				pend_last_q  <= (d_q == LEN_W'(0)) && final_row;
			end else if (out_load) begin
				pend_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q  <= s_req;
						x_q    <= s_tdata[5:0];
						y_q    <= s_tdata[8:6];
						nr_q   <= s_tdata[11:9];
						cmd_q  <= s_tdata[15:12];
						dat_q  <= s_tdata[23:16];
						d_q    <= len_m1;
						r_q    <= '0;
						base_q <= '0;
						case (s_req)
							REQ_SET_DOT, REQ_CLR_DOT: begin
								state_q <= ST_DOT_RD;
							end
							REQ_SHIFT_R: begin
								p_q     <= size_m1;
								col_q   <= len_m1;
								state_q <= ST_SH_PRIME;
							end
							REQ_SHIFT_L: begin
								p_q     <= '0;
								col_q   <= '0;
								state_q <= ST_SH_PRIME;
							end
							REQ_REFRESH, REQ_SEND_ALL: begin
								state_q <= ST_EMIT;
							end
							REQ_SEND_ONE: begin
								state_q <= (LEN_W'(s_tdata[11:9]) < len) ? ST_EMIT : ST_DRAIN;
							end
							default: begin
								state_q <= ST_DRAIN;
							end
						endcase
					end
				end
				ST_DOT_RD: begin
					state_q <= ST_DOT_WR;
				end
				ST_DOT_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SH_PRIME: begin
					state_q <= ST_SH_LOAD;
				end
				ST_SH_LOAD: begin
					cur_q   <= rd_val;
					state_q <= ST_SH_RUN;
				end
				ST_SH_RUN: begin
					if (sh_end) begin
						state_q <= ST_IDLE;
					end else begin
						p_q   <= nb1;
						cur_q <= rd_val;
						if (sh_left) begin
							col_q <= (col_q == len_m1) ? LEN_W'(0) : col_q + LEN_W'(1);
						end else begin
							col_q <= (col_q == LEN_W'(0)) ? len_m1 : col_q - LEN_W'(1);
						end
					end
				end
				ST_EMIT: begin
					if (issue) begin
						if (d_q == LEN_W'(0)) begin
							if (final_row) begin
								state_q <= ST_DRAIN;
							end else begin
								r_q    <= r_q + 3'd1;
								base_q <= base_q + ADDR_W'(len);
								d_q    <= len_m1;
							end
						end else begin
							d_q <= d_q - LEN_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (!pend_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, m_dat_q, m_cmd_q};
	assign m_tuser  = m_latch_q;
	assign m_tlast  = m_last_q;

endmodule

[design/lmcf_checker.sv]
// ----------------------------------------------------------------------------
// LED matrix chain frame buffer checker
// Port-level checks on the request and word streams, bound to the top level.
// ----------------------------------------------------------------------------
module lmcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled word keeps its contents until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output beat changed");

	// The final word of every request also latches the chain.
	a_last_latch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("final word without latch");

	// The block is never ready in the cycle after it accepts a request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready straight after an accepted request");

endmodule

bind led_matrix_chain_framebuffer lmcf_checker u_lmcf_checker (.*);
